[sv/aldw_pkg.sv]
// Shared types, register indexes and reset values for the addressable LED waveform driver.
// Used by every module of the block; depends on nothing else.

package aldw_pkg;

   localparam int unsigned MAX_LEDS_DEFAULT = 256;
   localparam int unsigned PIXEL_BITS       = 24;
   localparam int unsigned CSR_INDEX_W      = 3;
   localparam int unsigned CSR_DATA_W       = 12;
   localparam int unsigned QUEUE_DEPTH      = 2;

   localparam int unsigned BIT_PERIOD_DEFAULT = 1250;
   localparam int unsigned ZERO_DUTY_PERCENT  = 30;
   localparam int unsigned ONE_DUTY_PERCENT   = 70;
   localparam int unsigned LATCH_BITS_DEFAULT = 2;

   localparam logic [11:0] BIT_PERIOD_RESET = 12'(BIT_PERIOD_DEFAULT);
   localparam logic [11:0] ZERO_HIGH_RESET  =
      12'(BIT_PERIOD_DEFAULT * ZERO_DUTY_PERCENT / 100);
   localparam logic [11:0] ONE_HIGH_RESET   =
      12'(BIT_PERIOD_DEFAULT * ONE_DUTY_PERCENT / 100);
   localparam logic [7:0]  LATCH_BITS_RESET = 8'(LATCH_BITS_DEFAULT);

   localparam logic [CSR_INDEX_W-1:0] CSR_LED_COUNT  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BIT_PERIOD = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ZERO_HIGH  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ONE_HIGH   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_LATCH_BITS = 3'd4;

   typedef enum logic [1:0] {
      OP_TICK = 2'd0,
      OP_SET  = 2'd1,
      OP_FILL = 2'd2,
      OP_SHOW = 2'd3
   } op_type;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] led_index;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } req_type;

   typedef struct packed {
      logic line;
      logic busy_res;
      logic refused;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  led_count;
      logic [11:0] bit_period_ticks;
      logic [11:0] zero_high_ticks;
      logic [11:0] one_high_ticks;
      logic [7:0]  latch_bits;
   } cfg_type;

   typedef struct packed {
      op_type                op;
      logic [7:0]            led_index;
      logic [PIXEL_BITS-1:0] colour;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_head_type;

   typedef struct packed {
      logic pop;
      logic clearing;
   } back_status_type;

endpackage

[sv/aldw_csr.sv]
// Configuration registers of the LED waveform driver with their reset values.
// Depends on aldw_pkg.

module aldw_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [aldw_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [aldw_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output aldw_pkg::cfg_type                  cfg
);

   aldw_pkg::cfg_type cfg_ff;
   aldw_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            aldw_pkg::CSR_LED_COUNT:  cfg_in.led_count        = csr_wdata[7:0];
            aldw_pkg::CSR_BIT_PERIOD: cfg_in.bit_period_ticks = csr_wdata;
            aldw_pkg::CSR_ZERO_HIGH:  cfg_in.zero_high_ticks  = csr_wdata;
            aldw_pkg::CSR_ONE_HIGH:   cfg_in.one_high_ticks   = csr_wdata;
            aldw_pkg::CSR_LATCH_BITS: cfg_in.latch_bits       = csr_wdata[7:0];
            default:                  cfg_in                  = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.led_count        <= 8'd0;
         cfg_ff.bit_period_ticks <= aldw_pkg::BIT_PERIOD_RESET;
         cfg_ff.zero_high_ticks  <= aldw_pkg::ZERO_HIGH_RESET;
         cfg_ff.one_high_ticks   <= aldw_pkg::ONE_HIGH_RESET;
         cfg_ff.latch_bits       <= aldw_pkg::LATCH_BITS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[sv/aldw_front.sv]
// Request front end: accepts requests, decodes them into commands and queues them.
// Depends on aldw_pkg.

module aldw_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  aldw_pkg::req_type           req_data,
   input  aldw_pkg::back_status_type   status,
   output aldw_pkg::queue_head_type    head
);

   aldw_pkg::cmd_type entry_ff [aldw_pkg::QUEUE_DEPTH];
   logic              wr_ptr_ff;
   logic              wr_ptr_in;
   logic              rd_ptr_ff;
   logic              rd_ptr_in;
   logic [1:0]        count_ff;
   logic [1:0]        count_in;
   logic              push;
   aldw_pkg::cmd_type decoded;

   assign req_stall = (count_ff == 2'(aldw_pkg::QUEUE_DEPTH)) || status.clearing;
   assign push      = req_valid && !req_stall;

   always_comb begin
      decoded.op        = aldw_pkg::op_type'(req_data.mode);
      decoded.led_index = req_data.led_index;
      decoded.colour    = {req_data.green, req_data.red, req_data.blue};
   end

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = status.pop ? ~rd_ptr_ff : rd_ptr_ff;
      unique case ({push, status.pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= decoded;
      end
   end

   assign head.valid = (count_ff != 2'd0);
   assign head.cmd   = entry_ff[rd_ptr_ff];

endmodule

[sv/aldw_back.sv]
// Command back end: pixel store, fill sweep, frame serializer and the result register.
// Depends on aldw_pkg.

module aldw_back #(
   parameter int unsigned MAX_LEDS = aldw_pkg::MAX_LEDS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  aldw_pkg::cfg_type           cfg,
   input  aldw_pkg::queue_head_type    head,
   output aldw_pkg::back_status_type   status,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output aldw_pkg::rsp_type           rsp_data
);

   localparam int unsigned ADDR_W   = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
   localparam logic [12:0] LED_LIM  = 13'(MAX_LEDS);
   localparam int unsigned PB       = aldw_pkg::PIXEL_BITS;
   localparam logic [4:0]  LAST_BIT = 5'(PB - 1);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_LEDS - 1);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_RUN,
      ST_LOAD
   } state_type;

   logic [PB-1:0] pixel_mem [MAX_LEDS];

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] clear_addr_ff, clear_addr_in;
   logic              frame_active_ff, frame_active_in;
   logic              in_gap_ff, in_gap_in;
   logic              fill_active_ff, fill_active_in;
   logic [7:0]        pixel_pos_ff, pixel_pos_in;
   logic [4:0]        bit_pos_ff, bit_pos_in;
   logic [11:0]       tick_ff, tick_in;
   logic [7:0]        gap_ff, gap_in;
   logic [PB-1:0]     current_pixel_ff, current_pixel_in;
   logic [8:0]        fill_pos_ff, fill_pos_in;
   logic [PB-1:0]     fill_colour_ff, fill_colour_in;
   logic              load_oob_ff, load_oob_in;
   logic              rsp_valid_ff, rsp_valid_in;
   aldw_pkg::rsp_type rsp_ff, rsp_in;
   aldw_pkg::rsp_type pend_ff, pend_in;
   logic [PB-1:0]     rdata_ff;

   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [PB-1:0]     mem_wdata;
   logic [ADDR_W-1:0] mem_raddr;
   logic              out_free;
   logic              pop;
   logic              busy;
   logic              line_now;
   logic              need_load;
   logic              refused;
   logic [4:0]        bit_idx;
   logic [11:0]       high_ticks;
   logic [11:0]       tick_next;
   logic [7:0]        gap_next;
   logic [7:0]        pixel_next;
   logic [8:0]        fill_next;
   aldw_pkg::rsp_type result;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign pop      = (state_ff == ST_RUN) && head.valid && out_free;
   assign busy     = frame_active_ff || fill_active_ff;
   assign bit_idx  = LAST_BIT - bit_pos_ff;
   assign high_ticks = current_pixel_ff[bit_idx] ? cfg.one_high_ticks : cfg.zero_high_ticks;
   assign line_now = frame_active_ff && !in_gap_ff && (tick_ff < high_ticks);
   assign tick_next  = tick_ff + 12'd1;
   assign gap_next   = gap_ff + 8'd1;
   assign pixel_next = pixel_pos_ff + 8'd1;
   assign fill_next  = fill_pos_ff + 9'd1;

   always_comb begin
      state_in         = state_ff;
      clear_addr_in    = clear_addr_ff;
      frame_active_in  = frame_active_ff;
      in_gap_in        = in_gap_ff;
      fill_active_in   = fill_active_ff;
      pixel_pos_in     = pixel_pos_ff;
      bit_pos_in       = bit_pos_ff;
      tick_in          = tick_ff;
      gap_in           = gap_ff;
      current_pixel_in = current_pixel_ff;
      fill_pos_in      = fill_pos_ff;
      fill_colour_in   = fill_colour_ff;
      load_oob_in      = load_oob_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_in           = rsp_ff;
      pend_in          = pend_ff;
      mem_we           = 1'b0;
      mem_waddr        = clear_addr_ff;
      mem_wdata        = '0;
      mem_raddr        = '0;
      need_load        = 1'b0;
      refused          = 1'b0;
      result           = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we        = 1'b1;
            clear_addr_in = clear_addr_ff + ADDR_W'(1);
            if (clear_addr_ff == LAST_ADDR) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (pop) begin
               priority if (head.cmd.op == aldw_pkg::OP_TICK) begin
                  if (frame_active_ff) begin
                     if (cfg.bit_period_ticks > 12'd1 && tick_next < cfg.bit_period_ticks) begin
                        tick_in = tick_next;
                     end else begin
                        tick_in = 12'd0;
                        if (in_gap_ff) begin
                           gap_in = gap_next;
                           if (gap_next >= cfg.latch_bits) begin
                              frame_active_in = 1'b0;
                           end
                        end else if (bit_pos_ff != LAST_BIT) begin
                           bit_pos_in = bit_pos_ff + 5'd1;
                        end else begin
                           bit_pos_in   = 5'd0;
                           pixel_pos_in = pixel_next;
                           if (pixel_next >= cfg.led_count) begin
                              in_gap_in = 1'b1;
                              gap_in    = 8'd0;
                              if (cfg.latch_bits == 8'd0) begin
                                 frame_active_in = 1'b0;
                              end
                           end else begin
                              need_load   = 1'b1;
                              mem_raddr   = ADDR_W'(pixel_next);
                              load_oob_in = ({5'd0, pixel_next} >= LED_LIM);
                           end
                        end
                     end
                  end
                  if (fill_active_ff) begin
                     if ({4'd0, fill_pos_ff} < LED_LIM) begin
                        mem_we    = 1'b1;
                        mem_waddr = ADDR_W'(fill_pos_ff);
                        mem_wdata = fill_colour_ff;
                     end
                     if (fill_next >= {1'b0, cfg.led_count}) begin
                        fill_active_in = 1'b0;
                        fill_pos_in    = 9'd0;
                     end else begin
                        fill_pos_in = fill_next;
                     end
                  end
               end else if (busy) begin
                  refused = 1'b1;
               end else if (head.cmd.op == aldw_pkg::OP_SET) begin
                  if (head.cmd.led_index < cfg.led_count
                      && {5'd0, head.cmd.led_index} < LED_LIM) begin
                     mem_we    = 1'b1;
                     mem_waddr = ADDR_W'(head.cmd.led_index);
                     mem_wdata = head.cmd.colour;
                  end
               end else if (head.cmd.op == aldw_pkg::OP_FILL) begin
                  fill_colour_in = head.cmd.colour;
                  fill_pos_in    = 9'd0;
                  fill_active_in = (cfg.led_count != 8'd0);
               end else begin
                  frame_active_in = 1'b1;
                  pixel_pos_in    = 8'd0;
                  bit_pos_in      = 5'd0;
                  tick_in         = 12'd0;
                  gap_in          = 8'd0;
                  in_gap_in       = 1'b0;
                  if (cfg.led_count == 8'd0) begin
                     current_pixel_in = '0;
                     in_gap_in        = 1'b1;
                     if (cfg.latch_bits == 8'd0) begin
                        frame_active_in = 1'b0;
                     end
                  end else begin
                     need_load   = 1'b1;
                     mem_raddr   = '0;
                     load_oob_in = 1'b0;
                  end
               end

               result.line     = line_now;
               result.busy_res = frame_active_in || fill_active_in;
               result.refused  = refused;
               if (need_load) begin
                  pend_in  = result;
                  state_in = ST_LOAD;
               end else begin
                  rsp_in       = result;
                  rsp_valid_in = 1'b1;
               end
            end
         end
         ST_LOAD: begin
            current_pixel_in = load_oob_ff ? '0 : rdata_ff;
            rsp_in           = pend_ff;
            rsp_valid_in     = 1'b1;
            state_in         = ST_RUN;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_CLEAR;
         clear_addr_ff    <= '0;
         frame_active_ff  <= 1'b0;
         in_gap_ff        <= 1'b0;
         fill_active_ff   <= 1'b0;
         pixel_pos_ff     <= 8'd0;
         bit_pos_ff       <= 5'd0;
         tick_ff          <= 12'd0;
         gap_ff           <= 8'd0;
         current_pixel_ff <= '0;
         fill_pos_ff      <= 9'd0;
         fill_colour_ff   <= '0;
         load_oob_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         clear_addr_ff    <= clear_addr_in;
         frame_active_ff  <= frame_active_in;
         in_gap_ff        <= in_gap_in;
         fill_active_ff   <= fill_active_in;
         pixel_pos_ff     <= pixel_pos_in;
         bit_pos_ff       <= bit_pos_in;
         tick_ff          <= tick_in;
         gap_ff           <= gap_in;
         current_pixel_ff <= current_pixel_in;
         fill_pos_ff      <= fill_pos_in;
         fill_colour_ff   <= fill_colour_in;
         load_oob_ff      <= load_oob_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      rsp_ff  <= rsp_in;
      pend_ff <= pend_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         pixel_mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= pixel_mem[mem_raddr];
   end

   assign status.pop      = pop;
   assign status.clearing = (state_ff == ST_CLEAR);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_ff;

endmodule

[sv/addressable_led_waveform_driver.sv]
// Top level of the addressable LED waveform driver.
// Depends on aldw_pkg, aldw_csr, aldw_front and aldw_back.

// Each request is a tick, a pixel write, a fill of the first led_count pixels or a frame
// start, and each gives exactly one response carrying the line level for that tick, the busy
// flag after it and whether the command was refused. Requests pass through a two-entry queue,
// and the back end executes one request per cycle while its response register is free and no
// pixel load is pending; an accepted request is registered in the queue, then popped into the
// response register. A request that fetches a new pixel (a frame start, or a tick crossing
// into the next pixel) passes through the load state for the registered pixel memory read.
// After reset the pixel store is cleared one entry per cycle, and requests stall meanwhile.

module addressable_led_waveform_driver #(
   parameter int unsigned MAX_LEDS = aldw_pkg::MAX_LEDS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  aldw_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output aldw_pkg::rsp_type                  rsp_data,
   input  logic                               csr_we,
   input  logic [aldw_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [aldw_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   aldw_pkg::cfg_type         cfg;
   aldw_pkg::queue_head_type  head;
   aldw_pkg::back_status_type status;

   aldw_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   aldw_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .status    (status),
      .head      (head)
   );

   aldw_back #(
      .MAX_LEDS (MAX_LEDS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .head      (head),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

[sv/aldw_checker.sv]
// Port-level checks for the addressable LED waveform driver, bound to its top level.
// Depends on aldw_pkg and addressable_led_waveform_driver.

module aldw_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input aldw_pkg::rsp_type rsp_data
);

   // The pixel store is being cleared right after reset, so no request may enter.
   assert property (@(posedge clock) $fell(reset) |-> req_stall)
      else $error("request channel open during the clearing pass");

   // A refused command leaves the running frame or sweep running, so its response still reports busy.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.refused |-> rsp_data.busy_res)
      else $error("refused response without busy");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

endmodule

bind addressable_led_waveform_driver aldw_checker u_checker (.*);

[bench/aldw_waveform_checker.sv]
// Checker for the addressable LED waveform driver: follows register writes and requests,
// forecasts each response from its own copy of the pixel store and frame state, compares.
// Depends on aldw_pkg.

module aldw_waveform_checker
   import aldw_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  req_type                req_data,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  rsp_type                rsp_data,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     failures,
   output int                     pending
);

   cfg_type     regs;
   logic [23:0] pixels [MAX_LEDS_DEFAULT];
   logic        frame_on;
   logic        gap_phase;
   logic        fill_on;
   logic [7:0]  pixel_ptr;
   logic [4:0]  bit_ptr;
   logic [11:0] ticks;
   logic [7:0]  gap_ticks;
   logic [23:0] shift_pixel;
   logic [8:0]  fill_ptr;
   logic [23:0] fill_rgb;
   rsp_type     forecast_q [$];

   function automatic logic level_now();
      logic [11:0] high;
      if (!frame_on || gap_phase) begin
         return 1'b0;
      end
      high = shift_pixel[23 - bit_ptr] ? regs.one_high_ticks : regs.zero_high_ticks;
      return ticks < high;
   endfunction

   task automatic start_gap();
      gap_phase = 1'b1;
      gap_ticks = '0;
      if (regs.latch_bits == 0) begin
         frame_on = 1'b0;
      end
   endtask

   task automatic advance_frame();
      ticks = ticks + 12'd1;
      if (regs.bit_period_ticks > 1 && ticks < regs.bit_period_ticks) begin
         return;
      end
      ticks = '0;
      if (gap_phase) begin
         gap_ticks = gap_ticks + 8'd1;
         if (gap_ticks >= regs.latch_bits) begin
            frame_on = 1'b0;
         end
         return;
      end
      bit_ptr = bit_ptr + 5'd1;
      if (bit_ptr < 24) begin
         return;
      end
      bit_ptr = '0;
      pixel_ptr = pixel_ptr + 8'd1;
      if (pixel_ptr >= regs.led_count) begin
         start_gap();
      end else begin
         shift_pixel = pixels[pixel_ptr];
      end
   endtask

   task automatic advance_fill();
      if (fill_ptr < MAX_LEDS_DEFAULT) begin
         pixels[fill_ptr[7:0]] = fill_rgb;
      end
      fill_ptr = fill_ptr + 9'd1;
      if (fill_ptr >= regs.led_count) begin
         fill_on = 1'b0;
         fill_ptr = '0;
      end
   endtask

   task automatic forecast_response(input req_type r);
      rsp_type     e;
      logic        busy;
      logic [23:0] rgb;
      rgb = {r.green, r.red, r.blue};
      busy = frame_on || fill_on;
      e.line = level_now();
      e.refused = 1'b0;
      if (r.mode == OP_TICK) begin
         if (frame_on) begin
            advance_frame();
         end
         if (fill_on) begin
            advance_fill();
         end
      end else if (busy) begin
         e.refused = 1'b1;
      end else if (r.mode == OP_SET) begin
         if (r.led_index < regs.led_count) begin
            pixels[r.led_index] = rgb;
         end
      end else if (r.mode == OP_FILL) begin
         fill_rgb = rgb;
         fill_ptr = '0;
         fill_on = regs.led_count > 0;
      end else begin
         frame_on = 1'b1;
         pixel_ptr = '0;
         bit_ptr = '0;
         ticks = '0;
         gap_ticks = '0;
         gap_phase = 1'b0;
         if (regs.led_count == 0) begin
            shift_pixel = '0;
            start_gap();
         end else begin
            shift_pixel = pixels[0];
         end
      end
      e.busy_res = frame_on || fill_on;
      forecast_q.push_back(e);
   endtask

   task automatic compare_response(input rsp_type got);
      rsp_type e;
      if (forecast_q.size() == 0) begin
         $error("response with no request outstanding: line %0d busy %0d refused %0d",
                got.line, got.busy_res, got.refused);
         failures++;
         return;
      end
      e = forecast_q.pop_front();
      if (got.line !== e.line) begin
         $error("line: expected %0d, got %0d", e.line, got.line);
         failures++;
      end
      if (got.busy_res !== e.busy_res) begin
         $error("busy_res: expected %0d, got %0d", e.busy_res, got.busy_res);
         failures++;
      end
      if (got.refused !== e.refused) begin
         $error("refused: expected %0d, got %0d", e.refused, got.refused);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         regs.led_count = '0;
         regs.bit_period_ticks = BIT_PERIOD_RESET;
         regs.zero_high_ticks = ZERO_HIGH_RESET;
         regs.one_high_ticks = ONE_HIGH_RESET;
         regs.latch_bits = LATCH_BITS_RESET;
         for (int i = 0; i < MAX_LEDS_DEFAULT; i++) begin
            pixels[i] = '0;
         end
         frame_on = 1'b0;
         gap_phase = 1'b0;
         fill_on = 1'b0;
         pixel_ptr = '0;
         bit_ptr = '0;
         ticks = '0;
         gap_ticks = '0;
         shift_pixel = '0;
         fill_ptr = '0;
         fill_rgb = '0;
         forecast_q.delete();
         failures = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_LED_COUNT:  regs.led_count = csr_wdata[7:0];
               CSR_BIT_PERIOD: regs.bit_period_ticks = csr_wdata;
               CSR_ZERO_HIGH:  regs.zero_high_ticks = csr_wdata;
               CSR_ONE_HIGH:   regs.one_high_ticks = csr_wdata;
               CSR_LATCH_BITS: regs.latch_bits = csr_wdata[7:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            compare_response(rsp_data);
         end
         if (req_valid && !req_stall) begin
            forecast_response(req_data);
         end
      end
      pending = forecast_q.size();
   end

endmodule

[bench/addressable_led_waveform_driver_test.sv]
// Testbench top for the addressable LED waveform driver: reset, register settings, directed
// and random requests with random idling on both channels, and the final verdict.
// Depends on aldw_pkg, addressable_led_waveform_driver and aldw_waveform_checker.

module addressable_led_waveform_driver_test;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int RANDOM_PHASES  = 10;
   localparam int PHASE_REQUESTS = 55;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_stall;
   aldw_pkg::req_type                req_data = '0;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   aldw_pkg::rsp_type                rsp_data;
   logic                             csr_we = 1'b0;
   logic [aldw_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [aldw_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   int                failures;
   int                pending;
   int                stall_pct = 0;
   int                quiet_cycles = 0;
   logic              seen_busy = 1'b0;
   aldw_pkg::cfg_type active_cfg = '0;

   always #4 clock = ~clock;

   addressable_led_waveform_driver dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   aldw_waveform_checker waveform_check (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .failures  (failures),
      .pending   (pending)
   );

   always @(negedge clock) begin
      rsp_stall <= $urandom_range(0, 99) < stall_pct;
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (rsp_valid && !rsp_stall) begin
         seen_busy <= rsp_data.busy_res;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[addressable_led_waveform_driver] ERROR");
         $finish;
      end
   end

   function automatic aldw_pkg::req_type make_req(input aldw_pkg::op_type op,
                                                  input logic [7:0] idx,
                                                  input logic [7:0] g, input logic [7:0] r,
                                                  input logic [7:0] b);
      aldw_pkg::req_type q;
      q.mode = op;
      q.led_index = idx;
      q.green = g;
      q.red = r;
      q.blue = b;
      return q;
   endfunction

   function automatic aldw_pkg::req_type next_request();
      aldw_pkg::req_type q;
      int                pick;
      q.led_index = 8'($urandom);
      q.red = 8'($urandom);
      q.green = 8'($urandom);
      q.blue = 8'($urandom);
      pick = $urandom_range(0, 99);
      if (seen_busy) begin
         q.mode = (pick < 93) ? 2'(aldw_pkg::OP_TICK) : 2'($urandom_range(1, 3));
      end else if (pick < 40) begin
         q.mode = aldw_pkg::OP_SET;
         if (pick < 30) begin
            q.led_index = 8'($urandom_range(0, active_cfg.led_count));
         end
      end else if (pick < 55) begin
         q.mode = aldw_pkg::OP_TICK;
      end else if (pick < 62) begin
         q.mode = aldw_pkg::OP_FILL;
      end else begin
         q.mode = aldw_pkg::OP_SHOW;
      end
      return q;
   endfunction

   function automatic aldw_pkg::cfg_type phase_setting(input int ph);
      aldw_pkg::cfg_type c;
      if (ph == 0) begin
         c = '1;
      end else if (ph == 1) begin
         c = '0;
      end else begin
         c.led_count = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(1, 4));
         c.bit_period_ticks = ($urandom_range(0, 9) == 0) ? 12'($urandom)
                                                          : 12'($urandom_range(0, 6));
         c.zero_high_ticks = ($urandom_range(0, 9) == 0) ? 12'($urandom)
                                                         : 12'($urandom_range(0, 7));
         c.one_high_ticks = ($urandom_range(0, 9) == 0) ? 12'($urandom)
                                                        : 12'($urandom_range(0, 7));
         c.latch_bits = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
      end
      return c;
   endfunction

   task automatic send_request(input aldw_pkg::req_type q);
      @(negedge clock);
      req_valid = 1'b1;
      req_data = q;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
   endtask

   task automatic pause_sender(input int n);
      if (n == 0) begin
         return;
      end
      @(negedge clock);
      req_valid = 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic write_reg(input logic [aldw_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [aldw_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = value;
   endtask

   task automatic configure(input aldw_pkg::cfg_type c);
      drain();
      write_reg(aldw_pkg::CSR_LED_COUNT, 12'(c.led_count));
      write_reg(aldw_pkg::CSR_BIT_PERIOD, c.bit_period_ticks);
      write_reg(aldw_pkg::CSR_ZERO_HIGH, c.zero_high_ticks);
      write_reg(aldw_pkg::CSR_ONE_HIGH, c.one_high_ticks);
      write_reg(aldw_pkg::CSR_LATCH_BITS, 12'(c.latch_bits));
      @(negedge clock);
      csr_we = 1'b0;
      active_cfg = c;
   endtask

   initial begin
      int sent;
      int burst;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      stall_pct = 30;

      // Empty chain with a one-tick period: nothing starts and writes are dropped.
      configure('{8'd0, 12'd1, 12'd0, 12'd4095, 8'd0});
      send_request(make_req(aldw_pkg::OP_SHOW, 8'd0, 8'h00, 8'h00, 8'h00));
      send_request(make_req(aldw_pkg::OP_FILL, 8'd0, 8'hFF, 8'hFF, 8'hFF));
      send_request(make_req(aldw_pkg::OP_SET, 8'd0, 8'hFF, 8'hFF, 8'hFF));
      send_request(make_req(aldw_pkg::OP_TICK, 8'hFF, 8'hFF, 8'hFF, 8'hFF));

      // Empty chain with a latch gap: the frame holds only the low gap.
      configure('{8'd0, 12'd0, 12'd0, 12'd1, 8'd1});
      send_request(make_req(aldw_pkg::OP_SHOW, 8'd0, 8'h00, 8'h00, 8'h00));
      send_request(make_req(aldw_pkg::OP_SHOW, 8'd0, 8'h00, 8'h00, 8'h00));
      send_request(make_req(aldw_pkg::OP_TICK, 8'd0, 8'h00, 8'h00, 8'h00));
      send_request(make_req(aldw_pkg::OP_TICK, 8'd0, 8'h00, 8'h00, 8'h00));

      // Full chain, high time beyond the period, and commands refused during the frame.
      configure('{8'd255, 12'd2, 12'd1, 12'd4095, 8'd255});
      send_request(make_req(aldw_pkg::OP_SET, 8'd0, 8'hFF, 8'h00, 8'hAA));
      send_request(make_req(aldw_pkg::OP_SET, 8'd254, 8'hFF, 8'hFF, 8'hFF));
      send_request(make_req(aldw_pkg::OP_SET, 8'd255, 8'h55, 8'hA5, 8'h5A));
      send_request(make_req(aldw_pkg::OP_SHOW, 8'd0, 8'h00, 8'h00, 8'h00));
      send_request(make_req(aldw_pkg::OP_SET, 8'd1, 8'h12, 8'h34, 8'h56));
      send_request(make_req(aldw_pkg::OP_FILL, 8'd0, 8'h77, 8'h88, 8'h99));
      send_request(make_req(aldw_pkg::OP_SHOW, 8'd0, 8'h00, 8'h00, 8'h00));
      repeat (6) send_request(make_req(aldw_pkg::OP_TICK, 8'd0, 8'h00, 8'h00, 8'h00));

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         configure(phase_setting(ph));
         case ($urandom_range(0, 2))
            0: stall_pct = 0;
            1: stall_pct = 25;
            default: stall_pct = 60;
         endcase
         sent = 0;
         while (sent < PHASE_REQUESTS) begin
            burst = $urandom_range(1, 16);
            if (burst > PHASE_REQUESTS - sent) begin
               burst = PHASE_REQUESTS - sent;
            end
            repeat (burst) begin
               send_request(next_request());
               sent++;
            end
            if ($urandom_range(0, 29) == 0) begin
               drain();
            end else begin
               pause_sender($urandom_range(0, 1) * $urandom_range(1, 5));
            end
         end
      end

      drain();
      repeat (4) @(posedge clock);
      if (failures == 0) begin
         $display("[addressable_led_waveform_driver] OK");
      end else begin
         $display("[addressable_led_waveform_driver] ERROR");
      end
      $finish;
   end

endmodule
